[hw/rtl/msp_pkg.sv]
// Shared constants, codes and beat types of the multi-stack shared pool unit.
package msp_pkg;

  localparam int unsigned NUM_STACKS_DEF = 4;
  localparam int unsigned POOL_SIZE_DEF  = 64;
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned SEL_W          = 2;
  localparam int unsigned QUEUE_DEPTH    = 2;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_PUSHED = 2'd0,
    ST_FULL   = 2'd1,
    ST_POPPED = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  // Input beat.
  typedef struct packed {
    op_e                       operation;
    logic [SEL_W-1:0]          stack_select;
    logic signed [DATA_W-1:0]  push_value;
  } in_item_t;

  // Result beat.
  typedef struct packed {
    status_e                   status;
    logic signed [DATA_W-1:0]  pop_value;
  } out_item_t;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    op_e               op;
    logic              sel_ok;
    logic [SEL_W-1:0]  sel;
    logic [DATA_W-1:0] value;
  } cmd_t;

endpackage

[hw/rtl/msp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module msp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/msp_front.sv]
// Front end: accepts input beats, classifies them and queues the commands.
module msp_front #(
  parameter int unsigned NUM_STACKS = msp_pkg::NUM_STACKS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  msp_pkg::in_item_t in_item_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output msp_pkg::cmd_t     cmd_o
);

  localparam int unsigned Qd = msp_pkg::QUEUE_DEPTH;
  localparam int unsigned Pw = (Qd > 1) ? $clog2(Qd) : 1;
  localparam int unsigned Cw = $clog2(Qd + 1);

  msp_pkg::cmd_t  queue_q [Qd];
  msp_pkg::cmd_t  cmd_in;
  logic [Pw-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [Cw-1:0]  count_q, count_d;
  logic           push, pop;

  // Classify the beat: a stack number at or beyond the configured count is flagged.
  always_comb begin
    cmd_in.op     = in_item_i.operation;
    cmd_in.sel    = in_item_i.stack_select;
    cmd_in.sel_ok = (32'(in_item_i.stack_select) < NUM_STACKS);
    cmd_in.value  = in_item_i.push_value;
  end

  assign in_ready_o  = (count_q != Cw'(Qd));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == Pw'(Qd - 1)) ? '0 : wr_ptr_q + Pw'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == Pw'(Qd - 1)) ? '0 : rd_ptr_q + Pw'(1);
    end
    if (push && !pop) begin
      count_d = count_q + Cw'(1);
    end else if (pop && !push) begin
      count_d = count_q - Cw'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

[hw/rtl/msp_back.sv]
// Back end: carries out push and pop commands on the shared entry pool.
module msp_back #(
  parameter int unsigned NUM_STACKS = msp_pkg::NUM_STACKS_DEF,
  parameter int unsigned POOL_SIZE  = msp_pkg::POOL_SIZE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  msp_pkg::cmd_t      cmd_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output msp_pkg::out_item_t out_item_o
);

  localparam int unsigned PtrW   = $clog2(POOL_SIZE + 1);
  localparam int unsigned IdxW   = $clog2(POOL_SIZE);
  localparam int unsigned StkW   = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int unsigned DataW  = msp_pkg::DATA_W;
  localparam logic [PtrW-1:0] NullPtr = PtrW'(POOL_SIZE);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TOP  = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;

  logic [1:0]            state_q, state_d;
  msp_pkg::op_e          op_q, op_d;
  logic                  sel_ok_q, sel_ok_d;
  logic [StkW-1:0]       stk_q, stk_d;
  logic [DataW-1:0]      value_q, value_d;
  logic [IdxW-1:0]       slot_q, slot_d;
  logic [PtrW-1:0]       free_head_q, free_head_d;
  logic [PtrW-1:0]       hwm_q, hwm_d;
  logic [NUM_STACKS-1:0] top_vld_q, top_vld_d;
  logic                  out_valid_q, out_valid_d;
  msp_pkg::out_item_t    out_item_q, out_item_d;

  logic                  out_free, fresh, push_ok, pop_ok;
  logic [PtrW-1:0]       top_ptr, next_free;

  logic                  link_we, link_re;
  logic [IdxW-1:0]       link_waddr, link_raddr;
  logic [PtrW-1:0]       link_wdata, link_rdata;
  logic                  data_we, data_re;
  logic [DataW-1:0]      data_rdata;
  logic                  top_we, top_re;
  logic [PtrW-1:0]       top_wdata, top_rdata;

  // Entry storage: data words, links, and the per-stack top pointers.
  msp_ram #(.Width(DataW), .Depth(POOL_SIZE)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (free_head_q[IdxW-1:0]),
    .wdata_i (value_q),
    .re_i    (data_re),
    .raddr_i (top_ptr[IdxW-1:0]),
    .rdata_o (data_rdata)
  );

  msp_ram #(.Width(PtrW), .Depth(POOL_SIZE)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (link_re),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  msp_ram #(.Width(PtrW), .Depth(NUM_STACKS)) u_top_ram (
    .clk_i   (clk_i),
    .we_i    (top_we),
    .waddr_i (stk_q),
    .wdata_i (top_wdata),
    .re_i    (top_re),
    .raddr_i (StkW'(cmd_i.sel)),
    .rdata_o (top_rdata)
  );

  // Decode of the fetched pointers. Entries at or above the fill mark were
  // never taken, so their link is still the initial chain to the next entry.
  assign out_free  = !out_valid_q || out_ready_i;
  assign top_ptr   = (sel_ok_q && top_vld_q[stk_q]) ? top_rdata : NullPtr;
  assign fresh     = (free_head_q >= hwm_q);
  assign next_free = fresh ? (free_head_q + PtrW'(1)) : link_rdata;
  assign push_ok   = sel_ok_q && (free_head_q != NullPtr);
  assign pop_ok    = (top_ptr != NullPtr);

  assign cmd_ready_o = (state_q == S_IDLE);

  // Command sequencer.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    sel_ok_d    = sel_ok_q;
    stk_d       = stk_q;
    value_d     = value_q;
    slot_d      = slot_q;
    free_head_d = free_head_q;
    hwm_d       = hwm_q;
    top_vld_d   = top_vld_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;
    link_we     = 1'b0;
    link_waddr  = free_head_q[IdxW-1:0];
    link_wdata  = top_ptr;
    link_re     = 1'b0;
    link_raddr  = free_head_q[IdxW-1:0];
    data_we     = 1'b0;
    data_re     = 1'b0;
    top_we      = 1'b0;
    top_wdata   = free_head_q;
    top_re      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          op_d     = cmd_i.op;
          sel_ok_d = cmd_i.sel_ok;
          stk_d    = StkW'(cmd_i.sel);
          value_d  = cmd_i.value;
          link_re  = 1'b1;
          top_re   = 1'b1;
          state_d  = S_TOP;
        end
      end
      S_TOP: begin
        if (op_q == msp_pkg::OP_PUSH) begin
          if (out_free) begin
            state_d              = S_IDLE;
            out_valid_d          = 1'b1;
            out_item_d.status    = push_ok ? msp_pkg::ST_PUSHED : msp_pkg::ST_FULL;
            out_item_d.pop_value = '0;
            if (push_ok) begin
              data_we          = 1'b1;
              link_we          = 1'b1;
              top_we           = 1'b1;
              top_vld_d[stk_q] = 1'b1;
              free_head_d      = next_free;
              if (fresh) begin
                hwm_d = free_head_q + PtrW'(1);
              end
            end
          end
        end else if (!pop_ok) begin
          if (out_free) begin
            state_d              = S_IDLE;
            out_valid_d          = 1'b1;
            out_item_d.status    = msp_pkg::ST_EMPTY;
            out_item_d.pop_value = '0;
          end
        end else begin
          link_re    = 1'b1;
          link_raddr = top_ptr[IdxW-1:0];
          data_re    = 1'b1;
          slot_d     = top_ptr[IdxW-1:0];
          state_d    = S_POP;
        end
      end
      S_POP: begin
        if (out_free) begin
          top_we               = 1'b1;
          top_wdata            = link_rdata;
          link_we              = 1'b1;
          link_waddr           = slot_q;
          link_wdata           = free_head_q;
          free_head_d          = PtrW'(slot_q);
          out_valid_d          = 1'b1;
          out_item_d.status    = msp_pkg::ST_POPPED;
          out_item_d.pop_value = data_rdata;
          state_d              = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_head_q <= '0;
      hwm_q       <= '0;
      top_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      hwm_q       <= hwm_d;
      top_vld_q   <= top_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working payload and result register.
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    sel_ok_q   <= sel_ok_d;
    stk_q      <= stk_d;
    value_q    <= value_d;
    slot_q     <= slot_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[hw/rtl/multi_stack_shared_pool_unit.sv]
// Top level of the multi-stack shared pool unit: front end, command queue, back end.
//
//   Channel | Direction | Handshake              | Beat
//   in      | input     | in_valid_i / in_ready_o   | msp_pkg::in_item_t
//   out     | output    | out_valid_o / out_ready_i | msp_pkg::out_item_t
//
// In the back end a push passes S_IDLE and S_TOP and a pop S_POP as well; a pop
// reads the top pointer RAM first, then the link and data RAMs at the top entry.
// A push to a missing stack or onto a full pool, or a pop of a missing or empty
// stack, ends after the first read.
// The front queue holds 2 beats, so input is taken while the back end works.
// Reset is immediate: the free list's initial chain comes from a fill mark,
// so no clearing pass runs. The back end holds while the result register waits.
module multi_stack_shared_pool_unit #(
  parameter int unsigned NUM_STACKS = msp_pkg::NUM_STACKS_DEF,
  parameter int unsigned POOL_SIZE  = msp_pkg::POOL_SIZE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  msp_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output msp_pkg::out_item_t out_item_o
);

  logic          cmd_valid;
  logic          cmd_ready;
  msp_pkg::cmd_t cmd;

  // Accept and classify.
  msp_front #(.NUM_STACKS(NUM_STACKS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // Execute against the pool.
  msp_back #(.NUM_STACKS(NUM_STACKS), .POOL_SIZE(POOL_SIZE)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

[hw/rtl/msp_checker.sv]
// Port-level checker for the multi-stack shared pool unit, with its bind.
module msp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input msp_pkg::out_item_t out_item_o
);

  logic [2:0] pending_q, pending_d;
  logic       in_beat, out_beat;

  assign in_beat  = in_valid_i && in_ready_o;
  assign out_beat = out_valid_o && out_ready_i;

  // Beats taken in whose result has not gone out yet.
  always_comb begin
    pending_d = pending_q;
    if (in_beat && !out_beat) begin
      pending_d = pending_q + 3'd1;
    end else if (out_beat && !in_beat) begin
      pending_d = pending_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // No result without an input beat behind it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pending_q != 3'd0))
    else $error("result beat without a pending input beat");

  // Queue, back end and result register hold at most four beats in all.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd4)
    else $error("more beats in flight than the unit can hold");

  // With nothing in flight the unit must take input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q == 3'd0) |-> in_ready_o)
    else $error("input stalled while the unit is empty");

  // Only a pop that succeeded returns a nonzero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.status != msp_pkg::ST_POPPED)) |->
      (out_item_o.pop_value == '0))
    else $error("nonzero pop value on a result that is not a pop");

  // A stalled result beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("result beat changed while stalled");

endmodule

bind multi_stack_shared_pool_unit msp_checker u_msp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

[sim/tb_multi_stack_shared_pool_unit.sv]
// Self-checking testbench of the multi-stack shared pool unit with an in-bench predictor.
`timescale 1ns / 100ps

module tb_multi_stack_shared_pool_unit;

  localparam int unsigned STACKS   = msp_pkg::NUM_STACKS_DEF;
  localparam int unsigned POOL     = msp_pkg::POOL_SIZE_DEF;
  localparam int unsigned DATA_BITS = msp_pkg::DATA_W;
  localparam int unsigned SEL_BITS = msp_pkg::SEL_W;
  localparam int unsigned PTR_W    = $clog2(POOL + 1);
  localparam int unsigned IDX_W    = $clog2(POOL);
  localparam int unsigned STK_W    = (STACKS > 1) ? $clog2(STACKS) : 1;
  localparam int unsigned DRAIN_CYCLES = 12;

  typedef logic [PTR_W-1:0] ptr_t;
  localparam ptr_t NULL_PTR = ptr_t'(POOL);

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  msp_pkg::in_item_t  in_item_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  msp_pkg::out_item_t out_item_o;

  multi_stack_shared_pool_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // Clock with a 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state: data words, links, stack tops and the free list head.
  logic [DATA_BITS-1:0] slot_value [POOL];
  ptr_t                 slot_next  [POOL];
  ptr_t                 stack_head [STACKS];
  ptr_t                 free_list_head;

  msp_pkg::out_item_t pending_results [$];
  int unsigned mismatch_count = 0;

  // Traffic shaping knobs, in percent per cycle.
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;

  // Long receiver hold-off, timed by its own process.
  int unsigned hold_cycles = 0;
  logic        holding = 1'b0;
  event        hold_start;

  // Pool after reset: every entry free and chained in order, all stacks empty.
  function automatic void reset_pool_model();
    for (int i = 0; i < POOL; i++) begin
      slot_value[i] = '0;
      slot_next[i]  = ptr_t'(i + 1);
    end
    slot_next[POOL-1] = NULL_PTR;
    for (int s = 0; s < STACKS; s++) begin
      stack_head[s] = NULL_PTR;
    end
    free_list_head = '0;
  endfunction

  // Applies one push or pop to the pool model and returns the expected result.
  function automatic msp_pkg::out_item_t apply_stack_op(msp_pkg::in_item_t beat);
    msp_pkg::out_item_t res;
    logic [IDX_W-1:0]   slot;
    logic [STK_W-1:0]   sel;
    logic               sel_ok;
    res.status    = msp_pkg::ST_FULL;
    res.pop_value = '0;
    sel    = STK_W'(beat.stack_select);
    sel_ok = (32'(beat.stack_select) < STACKS);
    if (beat.operation == msp_pkg::OP_PUSH) begin
      // A missing stack or an exhausted free list both report full.
      if (sel_ok && free_list_head < POOL) begin
        slot             = free_list_head[IDX_W-1:0];
        free_list_head   = slot_next[slot];
        slot_value[slot] = beat.push_value;
        slot_next[slot]  = stack_head[sel];
        stack_head[sel]  = ptr_t'(slot);
        res.status       = msp_pkg::ST_PUSHED;
      end
    end else begin
      res.status = msp_pkg::ST_EMPTY;
      if (sel_ok && stack_head[sel] < POOL) begin
        slot            = stack_head[sel][IDX_W-1:0];
        stack_head[sel] = slot_next[slot];
        slot_next[slot] = free_list_head;
        free_list_head  = ptr_t'(slot);
        res.status      = msp_pkg::ST_POPPED;
        res.pop_value   = slot_value[slot];
      end
    end
    return res;
  endfunction

  // Every accepted input beat adds one expected result.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      pending_results.push_back(apply_stack_op(in_item_i));
    end
  end

  // Every accepted output beat is compared with the oldest expected result.
  always @(posedge clk_i) begin
    msp_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: status %0d pop_value %h",
               out_item_o.status, out_item_o.pop_value);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_item_o.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_item_o.status);
          mismatch_count++;
        end
        if (out_item_o.pop_value !== want.pop_value) begin
          $error("pop_value: expected %h, actual %h", want.pop_value, out_item_o.pop_value);
          mismatch_count++;
        end
      end
    end
  end

  // Receiver: random stalls, forced low during a hold-off.
  always @(negedge clk_i) begin
    if (holding) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Hold-off timer.
  initial begin
    forever begin
      @(hold_start);
      holding = 1'b1;
      repeat (hold_cycles) @(posedge clk_i);
      holding = 1'b0;
    end
  end

  // Offers one beat after a random idle gap and returns once it is accepted.
  task automatic send_beat(input msp_pkg::in_item_t beat);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_op(input msp_pkg::op_e op, input int unsigned sel,
                         input logic [DATA_BITS-1:0] val);
    msp_pkg::in_item_t beat;
    beat.operation    = op;
    beat.stack_select = SEL_BITS'(sel);
    beat.push_value   = val;
    send_beat(beat);
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Random value with the field extremes mixed in.
  function automatic logic [DATA_BITS-1:0] random_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random(input int count, input int unsigned push_pct);
    for (int n = 0; n < count; n++) begin
      send_op(($urandom_range(99) < push_pct) ? msp_pkg::OP_PUSH : msp_pkg::OP_POP,
              $urandom_range(STACKS - 1), random_value());
    end
  endtask

  // Extreme values on one stack, popped back in reverse order, then an empty pop.
  task automatic test_lifo_extremes();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    send_op(msp_pkg::OP_PUSH, 0, 32'h7FFF_FFFF);
    send_op(msp_pkg::OP_PUSH, 0, 32'h8000_0000);
    send_op(msp_pkg::OP_PUSH, 0, 32'hFFFF_FFFF);
    send_op(msp_pkg::OP_POP,  0, 32'h1234_5678);
    send_op(msp_pkg::OP_POP,  0, '0);
    send_op(msp_pkg::OP_POP,  0, '0);
    send_op(msp_pkg::OP_POP,  0, 32'hFFFF_FFFF);
  endtask

  // Every stack in use at once, interleaved, so the free list is reused out of order.
  task automatic test_all_stacks();
    send_op(msp_pkg::OP_POP,  3, '0);
    send_op(msp_pkg::OP_PUSH, 0, 32'h0000_0000);
    send_op(msp_pkg::OP_PUSH, 1, 32'hFFFF_FFFF);
    send_op(msp_pkg::OP_PUSH, 2, 32'h5555_5555);
    send_op(msp_pkg::OP_PUSH, 3, 32'hAAAA_AAAA);
    send_op(msp_pkg::OP_POP,  1, '0);
    send_op(msp_pkg::OP_PUSH, 2, 32'h0000_0001);
    send_op(msp_pkg::OP_POP,  3, '0);
    send_op(msp_pkg::OP_POP,  2, '0);
    send_op(msp_pkg::OP_POP,  2, '0);
    send_op(msp_pkg::OP_POP,  0, '0);
    send_op(msp_pkg::OP_POP,  1, '0);
    send_op(msp_pkg::OP_POP,  2, '0);
    send_op(msp_pkg::OP_POP,  3, '0);
    wait_for_results();
  endtask

  task automatic test_no_idling();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    run_random(250, 50);
  endtask

  // Push-heavy with a slow sender, so the pool runs out and pushes report full.
  task automatic test_fill_pool();
    sender_idle_pct = 85;
    recv_stall_pct  = 0;
    run_random(250, 85);
  endtask

  // Pop-heavy with a slow receiver, so the stacks run dry.
  task automatic test_drain_pool();
    sender_idle_pct = 0;
    recv_stall_pct  = 85;
    run_random(250, 15);
  endtask

  task automatic test_both_idle();
    sender_idle_pct = 13;
    recv_stall_pct  = 13;
    run_random(250, 50);
  endtask

  // Receiver holds off while the sender keeps offering, then the sender pauses.
  task automatic test_backpressure();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_cycles     = 300;
    ->hold_start;
    run_random(60, 60);
    wait_for_results();
  endtask

  task automatic test_mixed_tail();
    sender_idle_pct = 13;
    recv_stall_pct  = 40;
    run_random(200, 55);
  endtask

  // Timeout guard.
  initial begin
    #10_000_000;
    $display("tb_multi_stack_shared_pool_unit failed");
    $finish;
  end

  // Test sequence.
  initial begin
    reset_pool_model();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_lifo_extremes();
    test_all_stacks();
    test_no_idling();
    test_fill_pool();
    test_drain_pool();
    test_both_idle();
    test_backpressure();
    test_mixed_tail();

    wait_for_results();
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("tb_multi_stack_shared_pool_unit passed");
    end else begin
      $display("tb_multi_stack_shared_pool_unit failed");
    end
    $finish;
  end

endmodule
